>>> rtl/rsbd_pkg.sv
// Shared types and constants for the record date sorter.
// No dependencies; imported by rsbd_cell and record_sort_by_date.
package rsbd_pkg;

	// width of a packed YYYYMMDD date key
	localparam int unsigned KEY_W = 27;

	// per-cycle command broadcast along the cell chain
	typedef struct packed {
		logic insert; // place the arriving word into the chain
		logic drain;  // shift every cell one place towards the head
	} cell_ctrl_t;

endpackage

>>> rtl/rsbd_cell.sv
// One slot of the insertion chain: holds a key and a tag.
// Depends on rsbd_pkg for KEY_W and cell_ctrl_t.
module rsbd_cell import rsbd_pkg::*; #(
	parameter int unsigned TAG_WIDTH = 10
) (
	input  logic                 clk,
	input  cell_ctrl_t           ctrl,
	input  logic                 occupied,
	input  logic [KEY_W-1:0]     new_key,
	input  logic [TAG_WIDTH-1:0] new_tag,
	input  logic                 prev_gt,
	input  logic [KEY_W-1:0]     prev_key,
	input  logic [TAG_WIDTH-1:0] prev_tag,
	input  logic [KEY_W-1:0]     next_key,
	input  logic [TAG_WIDTH-1:0] next_tag,
	output logic                 gt,
	output logic [KEY_W-1:0]     key,
	output logic [TAG_WIDTH-1:0] tag
);

	logic [KEY_W-1:0]     key_q;
	logic [TAG_WIDTH-1:0] tag_q;

	// an empty slot counts as larger than any key
	assign gt = !occupied || (key_q > new_key);

	always_ff @(posedge clk) begin
		if (ctrl.insert && gt) begin
			key_q <= prev_gt ? prev_key : new_key;
			tag_q <= prev_gt ? prev_tag : new_tag;
		end else if (ctrl.drain) begin
			key_q <= next_key;
			tag_q <= next_tag;
		end
	end

	assign key = key_q;
	assign tag = tag_q;

endmodule

>>> rtl/record_sort_by_date.sv
// Top level of the record date sorter: control and the chain of cells.
// Depends on rsbd_pkg and rsbd_cell.
//
// Sorts dated records. Each accepted input word carries a YYYYMMDD key and
// a tag; it is slotted into a chain of MAX_RECORDS cells in the same cycle,
// behind every stored record whose key is less than or equal to its own, so
// equal keys keep arrival order. Loading runs at one word per cycle. The word
// flagged last_record is stored like the others and then the chain drains:
// one result word per cycle while res_stall is low, from the head cell,
// ascending by key, the last one flagged final_result. The drain gives one
// result word per stored record (1 to MAX_RECORDS words); rec_stall is held
// high for that whole drain, since the chain shifts towards the head as each
// result is taken. Words arriving with the chain full are discarded, and the
// final result of that set then shows records_dropped. Afterwards the chain
// is empty again. Keys are compared as plain 27-bit unsigned numbers.
module record_sort_by_date import rsbd_pkg::*; #(
	parameter int unsigned MAX_RECORDS = 64,
	parameter int unsigned TAG_WIDTH   = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// record input
	input  logic                 rec_valid,
	output logic                 rec_stall,
	input  logic [KEY_W-1:0]     date_key,
	input  logic [TAG_WIDTH-1:0] record_tag,
	input  logic                 last_record,
	// sorted output
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [KEY_W-1:0]     sorted_date,
	output logic [TAG_WIDTH-1:0] sorted_tag,
	output logic                 final_result,
	output logic                 records_dropped
);

	localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);

	typedef enum logic [1:0] {
		ST_LOAD  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic             overflow_q;

	logic       rec_acc;
	logic       res_acc;
	logic       full;
	cell_ctrl_t ctrl;

	// chain wiring: one entry per cell
	logic                 gt_w  [MAX_RECORDS];
	logic [KEY_W-1:0]     key_w [MAX_RECORDS];
	logic [TAG_WIDTH-1:0] tag_w [MAX_RECORDS];

	assign rec_stall = (state_q == ST_DRAIN);
	assign rec_acc   = rec_valid && !rec_stall;
	assign res_valid = (state_q == ST_DRAIN);
	assign res_acc   = res_valid && !res_stall;
	assign full      = (count_q == CNT_W'(MAX_RECORDS));

	// a full chain drops the word; drain only when a result word is taken
	assign ctrl.insert = rec_acc && !full;
	assign ctrl.drain  = res_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (rec_acc) begin
						if (full)
							overflow_q <= 1'b1;
						else
							count_q <= count_q + CNT_W'(1);
						if (last_record)
							state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (res_acc) begin
						count_q <= count_q - CNT_W'(1);
						if (count_q == CNT_W'(1)) begin
							overflow_q <= 1'b0;
							state_q    <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
		localparam int unsigned PREV = (i == 0) ? 0 : i - 1;
		localparam int unsigned NEXT = (i == MAX_RECORDS - 1) ? i : i + 1;

		logic occ;
		logic prev_gt;

		assign occ     = count_q > CNT_W'(i);
		// head cell always takes the new word when it must move
		assign prev_gt = (i == 0) ? 1'b0 : gt_w[PREV];

		rsbd_cell #(
			.TAG_WIDTH (TAG_WIDTH)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.occupied (occ),
			.new_key  (date_key),
			.new_tag  (record_tag),
			.prev_gt  (prev_gt),
			.prev_key (key_w[PREV]),
			.prev_tag (tag_w[PREV]),
			.next_key (key_w[NEXT]),
			.next_tag (tag_w[NEXT]),
			.gt       (gt_w[i]),
			.key      (key_w[i]),
			.tag      (tag_w[i])
		);
	end

	// head cell is the output register
	assign sorted_date     = key_w[0];
	assign sorted_tag      = tag_w[0];
	assign final_result    = (count_q == CNT_W'(1));
	assign records_dropped = final_result && overflow_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RECORDS))
		else $error("stored count beyond capacity");

	a_drop_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_acc && full) |=> overflow_q)
		else $error("dropped word not recorded");

	a_final_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(res_acc && final_result) |=> (!res_valid && !overflow_q && count_q == '0))
		else $error("chain not empty after final result");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (count_q != '0))
		else $error("result shown from empty chain");

endmodule
